[rtl/core/indexed_min_heap_macros.svh]
// Assertion macros used by the heap controller RTL.
`ifndef INDEXED_MIN_HEAP_MACROS_SVH
`define INDEXED_MIN_HEAP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define IMH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("imh: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define IMH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("imh: next-cycle check failed");

`endif

[rtl/core/imh_pkg.sv]
package imh_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = 10;
    localparam int KEY_BITS  = 31;
    localparam int SLOT_W    = $clog2(MAX_NODES + 1);
    localparam int ADDR_W    = $clog2(MAX_NODES);
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 56;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    typedef enum logic [2:0] {
        MODE_INSERT   = 3'd0,
        MODE_EXTRACT  = 3'd1,
        MODE_DECREASE = 3'd2,
        MODE_PEEK     = 3'd3,
        MODE_CLEAR    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_ABSENT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_NS_CHK, ST_SLOT_CHK, ST_UP_RD, ST_UP_CMP,
        ST_EX_TOP, ST_EX_LAST, ST_DN_RD, ST_DN_LEFT, ST_DN_RIGHT, ST_DN_CMP,
        ST_PEEK, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_NS, RD_PARENT, RD_ONE, RD_COUNT, RD_LEFT, RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE, WR_UP, WR_DOWN, WR_FIN
    } wr_sel_t;

    typedef enum logic [2:0] {
        S_HOLD, S_NS, S_NEW, S_ONE, S_PARENT, S_CHILD
    } s_sel_t;

    typedef enum logic [1:0] {
        C_HOLD, C_INC, C_DEC, C_CLR
    } cnt_op_t;

    typedef struct packed {
        logic    load_in;
        logic    ns_rd;
        logic    slot_rd;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        s_sel_t  s_sel;
        cnt_op_t cnt_op;
        logic    load_mov_rd;
        logic    child_left;
        logic    child_right;
        logic    load_top;
        logic    set_status;
        status_t status_val;
        logic    res_load;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  node_bad;
        logic  cnt_zero;
        logic  cnt_one;
        logic  cnt_full;
        logic  s_ok;
        logic  slot_match;
        logic  s_gt1;
        logic  has_left;
        logic  has_right;
        logic  up_less;
        logic  dn_more;
        logic  out_full;
    } dp_stat_t;

endpackage

[rtl/core/imh_datapath.sv]
module imh_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  imh_pkg::dp_cmd_t  cmd,
    output imh_pkg::dp_stat_t stat,
    input  imh_pkg::mode_t    in_mode,
    input  imh_pkg::node_t    in_node,
    input  imh_pkg::key_t     in_key,
    input  logic              out_ready,
    output logic              out_valid,
    output imh_pkg::node_t    out_node,
    output imh_pkg::key_t     out_key,
    output imh_pkg::status_t  out_status,
    output imh_pkg::slot_t    out_count
);
    import imh_pkg::*;

    // heap slots (key and node together) and node-to-slot table
    logic [KEY_BITS+NODE_W-1:0] slot_mem [MAX_NODES];
    slot_t                      ns_mem   [MAX_NODES];

    mode_t   mode_reg;
    node_t   node_reg;
    slot_t   count_reg, count_next;
    slot_t   s_reg, s_next;
    key_t    mkey_reg;
    node_t   mnode_reg;
    key_t    ckey_reg;
    node_t   cnode_reg;
    slot_t   cidx_reg;
    key_t    rd_key_reg;
    node_t   rd_node_reg;
    slot_t   rd_ns_reg;
    node_t   top_node_reg;
    key_t    top_key_reg;
    status_t status_reg;
    logic    out_valid_reg, out_valid_next;
    node_t   out_node_reg;
    key_t    out_key_reg;
    status_t out_status_reg;
    slot_t   out_count_reg;

    logic [SLOT_W:0] left_w;
    slot_t           rd_slot;
    addr_t           rd_addr;
    addr_t           wr_addr;
    key_t            wr_key;
    node_t           wr_node;
    node_t           wr_ns_node;

    assign left_w = {s_reg, 1'b0};

    always_comb begin
        case (cmd.rd_sel)
            RD_NS:     rd_slot = rd_ns_reg;
            RD_PARENT: rd_slot = s_reg >> 1;
            RD_ONE:    rd_slot = SLOT_W'(1);
            RD_COUNT:  rd_slot = count_reg;
            RD_LEFT:   rd_slot = left_w[SLOT_W-1:0];
            RD_RIGHT:  rd_slot = left_w[SLOT_W-1:0] | SLOT_W'(1);
            default:   rd_slot = s_reg;
        endcase
    end

    always_comb begin
        rd_addr = ADDR_W'(rd_slot - SLOT_W'(1));
        wr_addr = ADDR_W'(s_reg - SLOT_W'(1));
        case (cmd.wr_sel)
            WR_UP: begin
                wr_key  = rd_key_reg;
                wr_node = rd_node_reg;
            end
            WR_DOWN: begin
                wr_key  = ckey_reg;
                wr_node = cnode_reg;
            end
            default: begin
                wr_key  = mkey_reg;
                wr_node = mnode_reg;
            end
        endcase
        wr_ns_node = wr_node;
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_sel != WR_NONE) begin
            slot_mem[wr_addr] <= {wr_key, wr_node};
            ns_mem[wr_ns_node[ADDR_W-1:0]] <= s_reg;
        end
        if (cmd.slot_rd) begin
            {rd_key_reg, rd_node_reg} <= slot_mem[rd_addr];
        end
        if (cmd.ns_rd) begin
            rd_ns_reg <= ns_mem[node_reg[ADDR_W-1:0]];
        end
    end

    always_comb begin
        case (cmd.s_sel)
            S_NS:     s_next = rd_ns_reg;
            S_NEW:    s_next = count_reg + SLOT_W'(1);
            S_ONE:    s_next = SLOT_W'(1);
            S_PARENT: s_next = s_reg >> 1;
            S_CHILD:  s_next = cidx_reg;
            default:  s_next = s_reg;
        endcase
        case (cmd.cnt_op)
            C_INC:   count_next = count_reg + SLOT_W'(1);
            C_DEC:   count_next = count_reg - SLOT_W'(1);
            C_CLR:   count_next = '0;
            default: count_next = count_reg;
        endcase
        if (cmd.res_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg <= s_next;
        if (cmd.load_in) begin
            mode_reg     <= in_mode;
            node_reg     <= in_node;
            mkey_reg     <= in_key;
            mnode_reg    <= in_node;
            top_node_reg <= '0;
            top_key_reg  <= '0;
            status_reg   <= STAT_OK;
        end
        if (cmd.load_mov_rd) begin
            mkey_reg  <= rd_key_reg;
            mnode_reg <= rd_node_reg;
        end
        if (cmd.child_left) begin
            ckey_reg  <= rd_key_reg;
            cnode_reg <= rd_node_reg;
            cidx_reg  <= left_w[SLOT_W-1:0];
        end
        if (cmd.child_right && (ckey_reg > rd_key_reg)) begin
            ckey_reg  <= rd_key_reg;
            cnode_reg <= rd_node_reg;
            cidx_reg  <= left_w[SLOT_W-1:0] | SLOT_W'(1);
        end
        if (cmd.load_top) begin
            top_node_reg <= rd_node_reg;
            top_key_reg  <= rd_key_reg;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status_val;
        end
        if (cmd.res_load) begin
            out_node_reg   <= top_node_reg;
            out_key_reg    <= top_key_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
        end
    end

    always_comb begin
        stat.mode       = mode_reg;
        stat.node_bad   = {1'b0, node_reg} >= SLOT_W'(MAX_NODES);
        stat.cnt_zero   = count_reg == '0;
        stat.cnt_one    = count_reg == SLOT_W'(1);
        stat.cnt_full   = count_reg >= SLOT_W'(MAX_NODES);
        stat.s_ok       = (s_reg != '0) && (s_reg <= count_reg);
        stat.slot_match = rd_node_reg == node_reg;
        stat.s_gt1      = s_reg > SLOT_W'(1);
        stat.has_left   = left_w <= {1'b0, count_reg};
        stat.has_right  = left_w < {1'b0, count_reg};
        stat.up_less    = mkey_reg < rd_key_reg;
        stat.dn_more    = mkey_reg > ckey_reg;
        stat.out_full   = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_node   = out_node_reg;
    assign out_key    = out_key_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

[rtl/core/imh_ctrl.sv]
`include "indexed_min_heap_macros.svh"

module imh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  imh_pkg::dp_stat_t stat,
    output imh_pkg::dp_cmd_t  cmd
);
    import imh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (stat.mode)
                    MODE_INSERT, MODE_DECREASE: begin
                        state_next = stat.node_bad ? ST_DONE : ST_NS_CHK;
                    end
                    MODE_EXTRACT: state_next = stat.cnt_zero ? ST_DONE : ST_EX_TOP;
                    MODE_PEEK:    state_next = stat.cnt_zero ? ST_DONE : ST_PEEK;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_NS_CHK: state_next = ST_SLOT_CHK;
            ST_SLOT_CHK: begin
                if (stat.s_ok && stat.slot_match) begin
                    state_next = ST_UP_RD;
                end else if (stat.mode == MODE_DECREASE || stat.cnt_full) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_UP_RD;
                end
            end
            ST_UP_RD:    state_next = stat.s_gt1 ? ST_UP_CMP : ST_DONE;
            ST_UP_CMP:   state_next = stat.up_less ? ST_UP_RD : ST_DONE;
            ST_EX_TOP:   state_next = stat.cnt_one ? ST_DONE : ST_EX_LAST;
            ST_EX_LAST:  state_next = ST_DN_RD;
            ST_DN_RD:    state_next = stat.has_left ? ST_DN_LEFT : ST_DONE;
            ST_DN_LEFT:  state_next = stat.has_right ? ST_DN_RIGHT : ST_DN_CMP;
            ST_DN_RIGHT: state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = stat.dn_more ? ST_DN_RD : ST_DONE;
            ST_PEEK:     state_next = ST_DONE;
            ST_DONE: begin
                if (!stat.out_full) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd            = '0;
        cmd.rd_sel     = RD_NS;
        cmd.wr_sel     = WR_NONE;
        cmd.s_sel      = S_HOLD;
        cmd.cnt_op     = C_HOLD;
        cmd.status_val = STAT_OK;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_DECODE: begin
                case (stat.mode)
                    MODE_INSERT, MODE_DECREASE: begin
                        if (stat.node_bad) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = STAT_ABSENT;
                        end else begin
                            cmd.ns_rd = 1'b1;
                        end
                    end
                    MODE_EXTRACT, MODE_PEEK: begin
                        if (stat.cnt_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = STAT_EMPTY;
                        end else begin
                            cmd.slot_rd = 1'b1;
                            cmd.rd_sel  = RD_ONE;
                        end
                    end
                    MODE_CLEAR: cmd.cnt_op = C_CLR;
                    default: ;
                endcase
            end
            ST_NS_CHK: begin
                cmd.s_sel   = S_NS;
                cmd.slot_rd = 1'b1;
                cmd.rd_sel  = RD_NS;
            end
            ST_SLOT_CHK: begin
                if (stat.s_ok && stat.slot_match) begin
                    // present: sift up from its own slot
                end else if (stat.mode == MODE_DECREASE) begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = STAT_ABSENT;
                end else if (stat.cnt_full) begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = STAT_FULL;
                end else begin
                    cmd.cnt_op = C_INC;
                    cmd.s_sel  = S_NEW;
                end
            end
            ST_UP_RD: begin
                if (stat.s_gt1) begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = RD_PARENT;
                end else begin
                    cmd.wr_sel = WR_FIN;
                end
            end
            ST_UP_CMP: begin
                if (stat.up_less) begin
                    cmd.wr_sel = WR_UP;
                    cmd.s_sel  = S_PARENT;
                end else begin
                    cmd.wr_sel = WR_FIN;
                end
            end
            ST_EX_TOP: begin
                cmd.load_top = 1'b1;
                cmd.cnt_op   = C_DEC;
                cmd.slot_rd  = 1'b1;
                cmd.rd_sel   = RD_COUNT;
            end
            ST_EX_LAST: begin
                cmd.load_mov_rd = 1'b1;
                cmd.s_sel       = S_ONE;
            end
            ST_DN_RD: begin
                if (stat.has_left) begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = RD_LEFT;
                end else begin
                    cmd.wr_sel = WR_FIN;
                end
            end
            ST_DN_LEFT: begin
                cmd.child_left = 1'b1;
                if (stat.has_right) begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = RD_RIGHT;
                end
            end
            ST_DN_RIGHT: cmd.child_right = 1'b1;
            ST_DN_CMP: begin
                if (stat.dn_more) begin
                    cmd.wr_sel = WR_DOWN;
                    cmd.s_sel  = S_CHILD;
                end else begin
                    cmd.wr_sel = WR_FIN;
                end
            end
            ST_PEEK: cmd.load_top = 1'b1;
            ST_DONE: cmd.res_load = !stat.out_full;
            default: ;
        endcase
    end

    `IMH_ASSERT_IMP(a_inc_not_full, aclk, aresetn, cmd.cnt_op == C_INC, !stat.cnt_full)
    `IMH_ASSERT_IMP(a_dec_not_empty, aclk, aresetn, cmd.cnt_op == C_DEC, !stat.cnt_zero)
    `IMH_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, in_valid && in_ready, state_reg == ST_DECODE)
    `IMH_ASSERT_NXT(a_result_to_idle, aclk, aresetn, cmd.res_load, state_reg == ST_IDLE)

endmodule

[rtl/core/indexed_min_heap.sv]
// Indexed binary min-heap of node numbers ordered by key, with a node-to-slot
// table so that decrease-key finds its entry directly.
// Input channel s_*: one transaction per operation. s_tuser carries the mode
// (insert, extract minimum, decrease key, peek, clear); s_tdata carries the
// node number and key. Output channel m_*: exactly one transaction per
// operation, with the top node and key (extract and peek), the entry count
// after the operation in m_tdata, and the status code in m_tuser.
// One operation at a time: s_tready is high only while the controller idles.
// Insert and decrease climb one level per parent read and compare/move;
// extract descends one level per left read, right read and compare/move,
// the right read only where there is a right child.
// The sift pace is set by the single read port of the slot memory, which
// each level of a sift visits once or twice.
// Reset (aresetn low, synchronous) empties the heap and the output register;
// memories are not swept, as presence is checked against the slot itself.
// A stalled receiver holds the result in the output register; the next
// operation may be accepted and run, and waits at its end until it drains.
module indexed_min_heap (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [imh_pkg::S_DATA_W-1:0]  s_tdata,  // node_id[9:0], key_value[40:10], zero pad
    input  logic [2:0]                    s_tuser,  // mode[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [imh_pkg::M_DATA_W-1:0]  m_tdata,  // top_node[9:0], top_key[40:10],
                                                    // entry_count[51:41], zero pad
    output logic [1:0]                    m_tuser   // status[1:0]
);
    import imh_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    node_t    out_node;
    key_t     out_key;
    status_t  out_status;
    slot_t    out_count;
    mode_t    in_mode;

    assign in_mode = mode_t'(s_tuser);

    imh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imh_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (in_mode),
        .in_node    (s_tdata[NODE_W-1:0]),
        .in_key     (s_tdata[NODE_W+KEY_BITS-1:NODE_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_node   (out_node),
        .out_key    (out_key),
        .out_status (out_status),
        .out_count  (out_count)
    );

    // pack result, low field first, zero filled to whole bytes
    assign m_tdata = M_DATA_W'({out_count, out_key, out_node});
    assign m_tuser = out_status;

endmodule

[bench/heap_checker.sv]
`timescale 1ns / 100ps

module heap_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending_count
);
    import imh_pkg::*;

    typedef struct packed {
        node_t      top_node;
        key_t       top_key;
        status_t    status;
        logic [10:0] entry_count;
    } heap_result_t;

    key_t         hp_key [1:MAX_NODES];
    node_t        hp_node [1:MAX_NODES];
    int unsigned  node_pos [MAX_NODES];
    bit           node_in [MAX_NODES];
    int unsigned  hp_size;
    heap_result_t awaited_results [$];

    assign pending_count = awaited_results.size();

    function automatic void place(int unsigned s, key_t k, node_t n);
        hp_key[s]  = k;
        hp_node[s] = n;
        node_pos[n] = s;
    endfunction

    function automatic void climb(int unsigned s, key_t k, node_t n);
        while (s > 1 && k < hp_key[s/2]) begin
            place(s, hp_key[s/2], hp_node[s/2]);
            s = s / 2;
        end
        place(s, k, n);
    endfunction

    function automatic void sink_last(int unsigned last);
        key_t k;
        node_t n;
        int unsigned s, c;
        k = hp_key[last];
        n = hp_node[last];
        s = 1;
        while (2*s <= hp_size) begin
            c = 2*s;
            if (c < hp_size && hp_key[c] > hp_key[c+1]) c++;
            if (!(k > hp_key[c])) break;
            place(s, hp_key[c], hp_node[c]);
            s = c;
        end
        place(s, k, n);
    endfunction

    function automatic heap_result_t heap_apply(logic [2:0] op, node_t n, key_t k);
        heap_result_t r;
        r = '0;
        case (op)
            MODE_INSERT, MODE_DECREASE: begin
                if (node_in[n]) begin
                    climb(node_pos[n], k, n);
                end else if (op == MODE_DECREASE) begin
                    r.status = STAT_ABSENT;
                end else if (hp_size >= MAX_NODES) begin
                    r.status = STAT_FULL;
                end else begin
                    hp_size++;
                    node_in[n] = 1'b1;
                    climb(hp_size, k, n);
                end
            end
            MODE_EXTRACT, MODE_PEEK: begin
                if (hp_size == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.top_node = hp_node[1];
                    r.top_key  = hp_key[1];
                    if (op == MODE_EXTRACT) begin
                        node_in[hp_node[1]] = 1'b0;
                        hp_size--;
                        if (hp_size > 0) sink_last(hp_size + 1);
                    end
                end
            end
            MODE_CLEAR: begin
                hp_size = 0;
                foreach (node_in[i]) node_in[i] = 1'b0;
            end
            default: ;
        endcase
        r.entry_count = 11'(hp_size);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        hp_size = 0;
        foreach (node_in[i]) node_in[i] = 1'b0;
    end

    always @(posedge aclk) begin
        heap_result_t want;
        if (aresetn && s_tvalid && s_tready)
            awaited_results.push_back(heap_apply(s_tuser, s_tdata[9:0], s_tdata[40:10]));
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[9:0] != want.top_node)
                    report_mismatch("top_node", m_tdata[9:0], want.top_node);
                if (m_tdata[40:10] != want.top_key)
                    report_mismatch("top_key", m_tdata[40:10], want.top_key);
                if (m_tuser != want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[51:41] != want.entry_count)
                    report_mismatch("entry_count", m_tdata[51:41], want.entry_count);
            end
        end
    end
endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import imh_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count, pending_count;
    longint      cycle_count = 0;

    // idling odds in percent, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // nodes inserted by this bench and believed present, for well-formed decreases
    bit          in_heap [MAX_NODES];
    int unsigned live_count = 0;

    always #5 aclk = ~aclk;

    indexed_min_heap i_dut (.*);

    heap_checker i_checker (.*);

    // Timeout: a generous bound that allows for stalls on both sides.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_000_000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: a fresh ready decision on every falling edge.
    always @(negedge aclk)
        if (aresetn) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // One operation transaction; waits for acceptance. tvalid stays up after
    // acceptance until the next operation or an idle cycle replaces it.
    task automatic send_op(mode_t op, int unsigned node, int unsigned key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, key[30:0], node[9:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        // shadow of presence, only for shaping stimulus
        case (op)
            MODE_INSERT: if (!in_heap[node[9:0]] && live_count < MAX_NODES) begin
                in_heap[node[9:0]] = 1'b1;
                live_count++;
            end
            MODE_CLEAR: begin
                foreach (in_heap[i]) in_heap[i] = 1'b0;
                live_count = 0;
            end
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
    endtask

    task automatic random_ops(int unsigned n_ops);
        int unsigned pick, node, key;
        for (int unsigned i = 0; i < n_ops; i++) begin
            pick = $urandom_range(99);
            node = $urandom_range(1023);
            // small key range gives ties; sometimes the full 31 bits
            key = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(63);
            if (pick < 45) begin
                send_op(MODE_INSERT, node, key);
            end else if (pick < 70) begin
                send_op(MODE_EXTRACT, node, key);
            end else if (pick < 85) begin
                // mostly target a node that is in the heap
                if (live_count > 0 && $urandom_range(3) != 0)
                    for (int t = 0; t < 50 && !in_heap[node]; t++) node = $urandom_range(1023);
                send_op(MODE_DECREASE, node, key);
            end else if (pick < 95) begin
                send_op(MODE_PEEK, node, key);
            end else if (pick < 97) begin
                send_op(MODE_CLEAR, node, key);
            end else begin
                send_op(mode_t'($urandom_range(7, 5)), node, key);
            end
        end
    endtask

    initial begin
        foreach (in_heap[i]) in_heap[i] = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty errors, extremes, duplicates, absent decrease, ties
        send_op(MODE_EXTRACT, 0, 0);
        send_op(MODE_PEEK, 0, 0);
        send_op(MODE_DECREASE, 5, 1);
        send_op(MODE_INSERT, 1023, 32'h7FFF_FFFF);
        send_op(MODE_INSERT, 0, 0);
        send_op(MODE_INSERT, 341, 32'h2AAA_AAAA);
        send_op(MODE_INSERT, 682, 32'h5555_5555);
        send_op(MODE_INSERT, 7, 0);
        send_op(MODE_INSERT, 9, 0);
        send_op(MODE_PEEK, 0, 0);
        send_op(MODE_DECREASE, 1023, 3);
        send_op(MODE_DECREASE, 0, 32'h7FFF_FFFF);   // larger key written in place
        send_op(MODE_INSERT, 682, 1);                // already present: acts as decrease
        send_op(mode_t'(5), 0, 0);
        send_op(mode_t'(7), 1023, 32'h7FFF_FFFF);
        repeat (4) send_op(MODE_EXTRACT, 0, 0);
        send_op(MODE_CLEAR, 0, 0);
        send_op(MODE_PEEK, 0, 0);
        send_op(MODE_DECREASE, 341, 0);
        drain();

        // fill to capacity with every node number, then empty it
        for (int unsigned n = 0; n < MAX_NODES; n++) send_op(MODE_INSERT, n, $urandom_range(255));
        send_op(MODE_INSERT, 1023, 0);
        send_op(MODE_EXTRACT, 0, 0);
        send_op(MODE_INSERT, 5, 0);
        send_op(MODE_CLEAR, 0, 0);
        drain();

        // random phases with varying idling
        random_ops(200);
        send_idle_pct = 85;
        random_ops(120);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        random_ops(120);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        random_ops(150);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_ops(50);

        drain();
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
